// File: hw/rtl/llpd_pkg.sv
// Package with the shared constants and types of the laser line row peak detector.
package llpd_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int RefRows   = 25;

    localparam int ColW = $clog2(MaxWidth);
    localparam int RowW = $clog2(MaxHeight);
    localparam int SumW = ColW + ColW;
    localparam int CntW = ColW + 1;
    localparam int RefW = 8 + $clog2(RefRows + 1);

    localparam logic [7:0] MinLevelReset = 8'd25;
    localparam logic [8:0] RatioReset    = 9'd205;

    typedef enum logic [0:0] {
        CFG_MIN_LEVEL = 1'b0,
        CFG_RATIO     = 1'b1
    } cfg_index_t;

    // One closed row, handed from the front part to the back part.
    // The bank bit says which half of the line store holds its gray levels.
    typedef struct packed {
        logic [SumW-1:0] tie_sum;
        logic [CntW-1:0] tie_cnt;
        logic            found;
        logic            frame_end;
        logic            bank;
    } row_job_t;

endpackage

// File: hw/rtl/llpd_front.sv
// Front part: per-pixel difference, running maximum and tie accumulation, line store write.
module llpd_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               laser_gray,
    input  logic [7:0]               background_gray,
    input  logic                     last_in_row,
    input  logic                     last_in_frame,
    input  logic [7:0]               min_level,
    input  logic                     job_full,
    output logic                     job_push,
    output llpd_pkg::row_job_t       job,
    output logic                     wr_en,
    output logic [llpd_pkg::ColW:0]  wr_addr,
    output logic [7:0]               wr_data
);
    import llpd_pkg::*;

    logic [CntW-1:0] col_reg;
    logic [8:0]      max_reg;
    logic            valid_reg;
    logic [SumW-1:0] sum_reg;
    logic [CntW-1:0] cnt_reg;
    logic            bank_reg;

    logic            take;
    logic            in_row;
    logic [7:0]      diff;
    logic            new_max;
    logic            tie;
    logic [SumW-1:0] sum_next;
    logic [CntW-1:0] cnt_next;
    logic [8:0]      max_next;
    logic            valid_next;
    logic            row_close;

    assign full      = job_full;
    assign take      = push && !full;
    assign in_row    = !col_reg[CntW-1];
    assign diff      = (laser_gray > background_gray) ? laser_gray - background_gray : 8'd0;
    assign new_max   = in_row && (diff > min_level) && (!valid_reg || {1'b0, diff} > max_reg);
    assign tie       = in_row && !new_max && valid_reg && ({1'b0, diff} == max_reg);
    assign row_close = last_in_row || last_in_frame;

    // Tie tracking for the current pixel.
    always_comb
    begin
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        max_next   = max_reg;
        valid_next = valid_reg;
        if (new_max)
        begin
            sum_next   = SumW'(col_reg[ColW-1:0]);
            cnt_next   = CntW'(1);
            max_next   = {1'b0, diff};
            valid_next = 1'b1;
        end
        else if (tie)
        begin
            sum_next = sum_reg + SumW'(col_reg[ColW-1:0]);
            cnt_next = cnt_reg + CntW'(1);
        end
    end

    assign wr_en   = take && in_row;
    assign wr_addr = {bank_reg, col_reg[ColW-1:0]};
    assign wr_data = laser_gray;

    assign job_push      = take && row_close;
    assign job.tie_sum   = sum_next;
    assign job.tie_cnt   = cnt_next;
    assign job.found     = valid_next;
    assign job.frame_end = last_in_frame;
    assign job.bank      = bank_reg;

    // Row accumulators; each closed row flips the line store bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            max_reg   <= '0;
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (row_close)
            begin
                col_reg   <= '0;
                max_reg   <= '0;
                valid_reg <= 1'b0;
                sum_reg   <= '0;
                cnt_reg   <= '0;
                bank_reg  <= !bank_reg;
            end
            else
            begin
                if (in_row)
                    col_reg <= col_reg + CntW'(1);
                max_reg   <= max_next;
                valid_reg <= valid_next;
                sum_reg   <= sum_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

// File: hw/rtl/llpd_job_queue.sv
// Two-entry queue of closed rows between the front and the back parts.
module llpd_job_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  llpd_pkg::row_job_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output llpd_pkg::row_job_t rdata
);
    import llpd_pkg::*;

    row_job_t   mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= wdata;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= !wp_reg;
            if (pop && !empty)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

// File: hw/rtl/llpd_back.sv
// Back part: serial centre division, line store read, brightness filter and result register.
module llpd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_empty,
    input  llpd_pkg::row_job_t        job,
    output logic                      job_pop,
    input  logic [8:0]                ratio,
    output logic                      rd_en,
    output logic [llpd_pkg::ColW:0]   rd_addr,
    input  logic [7:0]                rd_data,
    output logic                      empty,
    input  logic                      pop,
    output logic [9:0]                row_index,
    output logic [9:0]                center_column,
    output logic                      peak_found,
    output logic                      accepted,
    output logic                      reference_row,
    output logic                      frame_end
);
    import llpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_MUL,
        S_CMP,
        S_OUT
    } state_t;

    localparam int DivSteps = SumW;
    localparam int StepW    = $clog2(DivSteps + 1);
    localparam int LhsW     = 8 + 8 + $clog2(RefRows + 1);
    localparam int RhsW     = 9 + RefW;

    state_t           state_reg;
    logic [SumW-1:0]  quo_reg;
    logic [CntW:0]    rem_reg;
    logic [CntW-1:0]  den_reg;
    logic [StepW-1:0] step_reg;
    logic             found_reg;
    logic             fend_reg;
    logic             bank_reg;
    logic [RowW-1:0]  row_reg;
    logic [RefW-1:0]  ref_sum_reg;
    logic [LhsW-1:0]  lhs_reg;
    logic [RhsW-1:0]  rhs_reg;
    logic [7:0]       gray_reg;
    logic             out_valid_reg;
    logic [ColW-1:0]  center_reg;

    logic [CntW:0]    rem_shift;
    logic             is_ref;
    logic [ColW-1:0]  center_sat;

    assign rem_shift  = {rem_reg[CntW-1:0], quo_reg[SumW-1]};
    assign is_ref     = {1'b0, row_reg} < (RowW + 1)'(RefRows);
    assign center_sat = (quo_reg >= SumW'(MaxWidth)) ? ColW'(MaxWidth - 1) : quo_reg[ColW-1:0];
    assign job_pop    = (state_reg == S_IDLE) && !job_empty;
    assign rd_en      = state_reg == S_READ;
    assign rd_addr    = {bank_reg, center_sat};
    assign empty      = !out_valid_reg;

    // Row sequencer with restoring divider and filter compare.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            ref_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            fend_reg      <= 1'b0;
            bank_reg      <= 1'b0;
            lhs_reg       <= '0;
            rhs_reg       <= '0;
            gray_reg      <= '0;
            center_reg    <= '0;
            accepted      <= 1'b0;
            reference_row <= 1'b0;
            peak_found    <= 1'b0;
            frame_end     <= 1'b0;
            row_index     <= '0;
            center_column <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!job_empty)
                    begin
                        found_reg <= job.found;
                        fend_reg  <= job.frame_end;
                        bank_reg  <= job.bank;
                        den_reg   <= job.tie_cnt;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        if (job.found && job.tie_cnt != '0)
                        begin
                            quo_reg   <= job.tie_sum;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            quo_reg   <= '0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_DIV:
                begin
                    // One quotient bit per cycle.
                    if (rem_shift >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_shift - {1'b0, den_reg};
                        quo_reg <= {quo_reg[SumW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[SumW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + StepW'(1);
                    if (step_reg == StepW'(DivSteps - 1))
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    center_reg <= center_sat;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    gray_reg  <= rd_data;
                    lhs_reg   <= LhsW'(rd_data) * LhsW'(256 * RefRows);
                    rhs_reg   <= RhsW'(ratio) * RhsW'(ref_sum_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        row_index     <= 10'(row_reg);
                        center_column <= 10'(center_reg);
                        peak_found    <= found_reg;
                        reference_row <= is_ref;
                        accepted      <= is_ref || (RhsW'(lhs_reg) > rhs_reg);
                        frame_end     <= fend_reg;
                        if (fend_reg)
                        begin
                            row_reg     <= '0;
                            ref_sum_reg <= '0;
                        end
                        else
                        begin
                            if (is_ref)
                                ref_sum_reg <= ref_sum_reg + RefW'(gray_reg);
                            if (row_reg != RowW'(MaxHeight - 1))
                                row_reg <= row_reg + RowW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/laser_line_row_peak_detector_unit.sv
// A row result passes the job queue, then the serial divider when a peak was found, then the line
// store read, the multiply and the compare before it is ready; rows without a peak skip the divider.
// The input takes one pixel per cycle, but it stalls while two closed rows still wait for their
// line store read.
// Reset: asynchronous, active low; clears counters, the queue and registers to defaults.
// The two-bank line store is not cleared: every read hits an entry written in the same row.
module laser_line_row_peak_detector_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] laser_gray,
    input  logic [7:0] background_gray,
    input  logic       last_in_row,
    input  logic       last_in_frame,
    output logic       empty,
    input  logic       pop,
    output logic [9:0] row_index,
    output logic [9:0] center_column,
    output logic       peak_found,
    output logic       accepted,
    output logic       reference_row,
    output logic       frame_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data
);
    import llpd_pkg::*;

    logic [7:0]      min_level_reg;
    logic [8:0]      ratio_reg;
    logic [7:0]      line_mem [2 * MaxWidth];
    logic [7:0]      rd_data_reg;
    logic [1:0]      busy_rows_reg;

    logic            job_push;
    logic            job_full;
    logic            job_empty;
    logic            job_pop;
    logic            front_hold;
    row_job_t        job_in;
    row_job_t        job_out;
    logic            wr_en;
    logic [ColW:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [ColW:0]   rd_addr;

    assign cfg_ready = 1'b1;

    // The front part may only fill a bank whose previous row has been read.
    assign front_hold = job_full || (busy_rows_reg == 2'd2);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= MinLevelReset;
            ratio_reg     <= RatioReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_LEVEL: min_level_reg <= cfg_data[7:0];
                CFG_RATIO:     ratio_reg     <= cfg_data;
                default:       ratio_reg     <= ratio_reg;
            endcase
        end
    end

    // Count of closed rows whose centre gray level has not yet been read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_rows_reg <= 2'd0;
        else
            busy_rows_reg <= busy_rows_reg + 2'(job_push ? 1 : 0) - 2'(rd_en ? 1 : 0);
    end

    // Two-bank line store of with-laser gray levels.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
    end

    llpd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .laser_gray      (laser_gray),
        .background_gray (background_gray),
        .last_in_row     (last_in_row),
        .last_in_frame   (last_in_frame),
        .min_level       (min_level_reg),
        .job_full        (front_hold),
        .job_push        (job_push),
        .job             (job_in),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data)
    );

    llpd_job_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .empty (job_empty),
        .rdata (job_out)
    );

    llpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_empty     (job_empty),
        .job           (job_out),
        .job_pop       (job_pop),
        .ratio         (ratio_reg),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data_reg),
        .empty         (empty),
        .pop           (pop),
        .row_index     (row_index),
        .center_column (center_column),
        .peak_found    (peak_found),
        .accepted      (accepted),
        .reference_row (reference_row),
        .frame_end     (frame_end)
    );

    // A reference row result always passes the filter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reference_row) |-> accepted)
        else $error("reference row not accepted");

    // No centre without a peak.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !peak_found) |-> (center_column == 10'd0))
        else $error("centre given without a peak");

    // A closed row is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("row job lost");

endmodule

// File: dv/tb_laser_line_row_peak_detector_unit.sv
// Self-checking testbench for the laser line row peak detector unit.
`timescale 1ns / 100ps

module tb_laser_line_row_peak_detector_unit;
    import llpd_pkg::*;

    // Idle modes of the sender and the receiver.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int RandomItems = 300;
    localparam int SettleCycles = 60;

    typedef struct {
        logic [9:0] row;
        logic [9:0] col;
        logic       found;
        logic       acc;
        logic       is_ref;
        logic       last;
    } row_result_t;

    typedef struct {
        logic [7:0]  lg;
        logic [7:0]  bg;
        logic        lir;
        logic        lif;
        bit          typed;
        row_result_t res;
    } pixel_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] laser_gray;
    logic [7:0] background_gray;
    logic       last_in_row;
    logic       last_in_frame;
    logic       empty;
    logic       pop;
    logic [9:0] row_index;
    logic [9:0] center_column;
    logic       peak_found;
    logic       accepted;
    logic       reference_row;
    logic       res_frame_end;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [8:0] cfg_data;

    laser_line_row_peak_detector_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .laser_gray     (laser_gray),
        .background_gray(background_gray),
        .last_in_row    (last_in_row),
        .last_in_frame  (last_in_frame),
        .empty          (empty),
        .pop            (pop),
        .row_index      (row_index),
        .center_column  (center_column),
        .peak_found     (peak_found),
        .accepted       (accepted),
        .reference_row  (reference_row),
        .frame_end      (res_frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Predictor state.
    logic [7:0]  line_gray [MaxWidth];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned max_lvl;
    bit          max_valid;
    int unsigned tie_sum;
    int unsigned tie_cnt;
    int unsigned ref_sum;
    int unsigned min_lvl;
    int unsigned ratio;

    row_result_t pending_rows[$];
    pixel_row_t  directed[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          items_sent = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Timeout guard.
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // Works out the row result closed by one pixel, if any.
    function automatic bit predict_row(input logic [7:0] lg, input logic [7:0] bg,
                                       input logic lir, input logic lif,
                                       output row_result_t res);
        int unsigned diff;
        int unsigned centre;
        int unsigned gray;
        bit          is_ref;
        bit          acc;
        longint unsigned lhs;
        longint unsigned rhs;
        if (col_cnt < MaxWidth)
        begin
            diff = (lg > bg) ? lg - bg : 0;
            line_gray[col_cnt] = lg;
            if (diff > min_lvl && (!max_valid || diff > max_lvl))
            begin
                max_valid = 1'b1;
                max_lvl = diff;
                tie_sum = col_cnt;
                tie_cnt = 1;
            end
            else if (max_valid && diff == max_lvl)
            begin
                tie_sum += col_cnt;
                tie_cnt++;
            end
            col_cnt++;
        end
        if (!(lir || lif))
            return 1'b0;
        centre = 0;
        if (max_valid && tie_cnt != 0)
            centre = tie_sum / tie_cnt;
        if (centre >= MaxWidth)
            centre = MaxWidth - 1;
        gray = line_gray[centre];
        is_ref = row_cnt < RefRows;
        acc = 1'b1;
        if (is_ref)
            ref_sum += gray;
        else
        begin
            lhs = longint'(gray) * 256 * RefRows;
            rhs = longint'(ratio) * ref_sum;
            acc = lhs > rhs;
        end
        res.row = row_cnt[9:0];
        res.col = centre[9:0];
        res.found = max_valid;
        res.acc = acc;
        res.is_ref = is_ref;
        res.last = lif;
        col_cnt = 0;
        max_lvl = 0;
        max_valid = 1'b0;
        tie_sum = 0;
        tie_cnt = 0;
        if (lif)
        begin
            row_cnt = 0;
            ref_sum = 0;
        end
        else if (row_cnt < MaxHeight - 1)
            row_cnt++;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Receiver: checks every popped transaction against the oldest expectation.
    initial
    begin
        row_result_t exp_r;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_rows.size() == 0)
                begin
                    $error("row result with no expectation waiting");
                    errors++;
                end
                else
                begin
                    exp_r = pending_rows.pop_front();
                    check_field("row_index", exp_r.row, row_index);
                    check_field("center_column", exp_r.col, center_column);
                    check_field("peak_found", exp_r.found, peak_found);
                    check_field("accepted", exp_r.acc, accepted);
                    check_field("reference_row", exp_r.is_ref, reference_row);
                    check_field("frame_end", exp_r.last, res_frame_end);
                end
            end
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop = 1'b0;
            end
            else
                pop = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one pixel transaction until accepted, then predicts.
    // Starts and ends at a falling edge; push stays high for a following transaction.
    task automatic send_pixel(input logic [7:0] lg, input logic [7:0] bg,
                              input logic lir, input logic lif,
                              input bit typed, input row_result_t typed_res);
        row_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        laser_gray = lg;
        background_gray = bg;
        last_in_row = lir;
        last_in_frame = lif;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (predict_row(lg, bg, lir, lif, res))
            pending_rows.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic pixel(input logic [7:0] lg, input logic [7:0] bg,
                         input logic lir, input logic lif);
        row_result_t none;
        none = '{default: 0};
        send_pixel(lg, bg, lir, lif, 1'b0, none);
    endtask

    // Stops the sender, waits for every expected row, then lets the back end settle.
    task automatic drain();
        push = 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [8:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MIN_LEVEL)
            min_lvl = data[7:0];
        else
            ratio = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One row with a laser peak of a given level; ties come from a flat top.
    task automatic send_row(input int width, input int level, input bit close_frame);
        int pk_col;
        int pk_w;
        logic [7:0] lg;
        logic [7:0] bg;
        bit lir;
        bit lif;
        pk_col = $urandom_range(width - 1);
        pk_w = $urandom_range(1, 4);
        for (int c = 0; c < width; c++)
        begin
            if ($urandom_range(9) == 0)
            begin
                lg = 8'($urandom);
                bg = 8'($urandom);
            end
            else if (c >= pk_col && c < pk_col + pk_w)
            begin
                lg = 8'(level);
                bg = 8'd0;
            end
            else
            begin
                lg = 8'($urandom_range(level / 2));
                bg = 8'($urandom_range(40));
            end
            lir = (c == width - 1);
            lif = 1'b0;
            if (c == width - 1 && close_frame)
            begin
                lif = 1'b1;
                lir = 1'($urandom_range(1));
            end
            // Now and then a frame is cut short in the middle of a row.
            if (c != width - 1 && $urandom_range(499) == 0)
            begin
                lif = 1'b1;
                lir = 1'b0;
            end
            pixel(lg, bg, lir, lif);
        end
    endtask

    task automatic send_frame(input int rows, input int max_w);
        int base;
        int lvl;
        base = $urandom_range(40, 255);
        for (int r = 0; r < rows; r++)
        begin
            lvl = base + $urandom_range(80) - 50;
            if (lvl < 0)
                lvl = 0;
            if (lvl > 255)
                lvl = 255;
            send_row($urandom_range(1, max_w), lvl, r == rows - 1);
        end
    endtask

    task automatic add_dir(input logic [7:0] lg, input logic [7:0] bg, input logic lir,
                           input logic lif, input bit typed, input row_result_t res);
        pixel_row_t p;
        p.lg = lg;
        p.bg = bg;
        p.lir = lir;
        p.lif = lif;
        p.typed = typed;
        p.res = res;
        directed.push_back(p);
    endtask

    initial
    begin
        row_result_t none;
        row_result_t r0;
        row_result_t r1;
        int phase;
        none = '{default: 0};
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        laser_gray = '0;
        background_gray = '0;
        last_in_row = 1'b0;
        last_in_frame = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_LEVEL;
        cfg_data = '0;
        min_lvl = MinLevelReset;
        ratio = RatioReset;
        col_cnt = 0;
        row_cnt = 0;
        max_lvl = 0;
        max_valid = 1'b0;
        tie_sum = 0;
        tie_cnt = 0;
        ref_sum = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: extremes, ties, threshold edges, frame end forms.
        r0 = '{row: 10'd0, col: 10'd0, found: 1'b1, acc: 1'b1, is_ref: 1'b1, last: 1'b0};
        r1 = '{row: 10'd1, col: 10'd0, found: 1'b0, acc: 1'b1, is_ref: 1'b1, last: 1'b0};
        add_dir(8'd255, 8'd0, 1'b1, 1'b0, 1'b1, r0);
        add_dir(8'd0, 8'd255, 1'b1, 1'b0, 1'b1, r1);
        add_dir(8'd100, 8'd0, 1'b0, 1'b0, 1'b0, none);
        add_dir(8'd50, 8'd0, 1'b0, 1'b0, 1'b0, none);
        add_dir(8'd100, 8'd0, 1'b1, 1'b0, 1'b0, none);
        add_dir(8'd26, 8'd0, 1'b1, 1'b0, 1'b0, none);
        add_dir(8'd25, 8'd0, 1'b1, 1'b0, 1'b0, none);
        add_dir(8'd7, 8'd3, 1'b0, 1'b0, 1'b0, none);
        add_dir(8'd200, 8'd10, 1'b0, 1'b1, 1'b0, none);
        add_dir(8'd0, 8'd0, 1'b1, 1'b1, 1'b0, none);
        add_dir(8'd128, 8'd127, 1'b1, 1'b0, 1'b0, none);
        foreach (directed[i])
            send_pixel(directed[i].lg, directed[i].bg, directed[i].lir, directed[i].lif,
                       directed[i].typed, directed[i].res);
        drain();

        // Back pressure: the receiver holds off while short rows keep coming.
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            pixel(8'($urandom), 8'($urandom), 1'b1, i == 19);
        drain();

        // Random phases across register settings and idle modes.
        phase = 0;
        while (phase < 4 || items_sent < RandomItems)
        begin
            case (phase % 4)
                0: begin write_reg(CFG_MIN_LEVEL, 9'd0);   write_reg(CFG_RATIO, 9'd0);   end
                1: begin write_reg(CFG_MIN_LEVEL, 9'd255); write_reg(CFG_RATIO, 9'd256); end
                2: begin write_reg(CFG_MIN_LEVEL, 9'd25);  write_reg(CFG_RATIO, 9'd205); end
                default:
                begin
                    write_reg(CFG_MIN_LEVEL, 9'($urandom_range(255)));
                    write_reg(CFG_RATIO, 9'($urandom_range(256)));
                end
            endcase
            case (phase % 4)
                IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SEND: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default:   begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            send_frame(($urandom_range(2) == 0) ? $urandom_range(1, 24)
                                                : $urandom_range(26, 36), 6);
            drain();
            phase++;
        end

        // Over-wide row, without idling.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_MIN_LEVEL, 9'($urandom_range(60)));
        for (int c = 0; c < MaxWidth + 6; c++)
            pixel(8'($urandom), 8'($urandom), c == MaxWidth + 5, 1'b0);
        drain();

        if (errors == 0 && pending_rows.size() == 0)
            $display("Test completed successfully");
        else
        begin
            if (pending_rows.size() != 0)
                $error("%0d expected row results never arrived", pending_rows.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
